@@ rtl/jse_pkg.sv @@
// Shared types and constants for the JSON string escaper.
// Used by jse_decode, jse_emit and json_string_escaper; no dependencies.
`default_nettype none

package jse_pkg;

   // token slots filled by the decoder for one transfer, in output order
   localparam int NUM_SLOTS = 6;
   localparam int SLOT_W    = 3;

   localparam logic [SLOT_W-1:0] SLOT_OPEN  = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_BYTE  = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_REPL  = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_POS1  = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_POS2  = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_CLOSE = 3'd5;

   // token kinds: plain char, two-char escape, \uXXXX, surrogate pair
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_ESC  = 2'd1;
   localparam logic [1:0] KIND_U16  = 2'd2;
   localparam logic [1:0] KIND_PAIR = 2'd3;

   localparam logic [6:0] CHAR_QUOTE  = 7'h22;
   localparam logic [6:0] CHAR_BSLASH = 7'h5c;
   localparam logic [6:0] CHAR_U      = 7'h75;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] hi;
      logic [15:0] lo;
   } tok_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]          mask;
      tok_type [NUM_SLOTS-1:0]       toks;
   } job_type;

endpackage

`default_nettype wire

@@ rtl/json_string_escaper.sv @@
// Top level of the JSON string escaper: stream ports, decoder and emitter.
// Depends on jse_pkg, jse_decode and jse_emit.
//
// Usage: string bytes enter on the req_ stream, one transfer per byte. tuser
// carries has_byte and first_of_string, tlast marks the final transfer of a
// string. The rsp_ stream carries the quoted, escaped JSON text one ASCII
// character per transfer; rsp_tlast marks the last character caused by an
// input transfer and rsp_tuser marks the closing quote.
// A transfer's tokens go to the token register, then each character to the
// output register. Throughput: one character per cycle while the receiver
// does not stall; a transfer that produces one character is taken every
// cycle, one producing more holds req_tready low until the character
// sequencer has walked its tokens. Transfers that produce no character
// (held UTF-8 bytes, bytes after a NUL) load no tokens and do not stall.
// Reset clears the sequence state and both valid flags. When the receiver
// stalls, the output register holds its character and the next input
// transfer is still taken once the current one has been fully handed over.
`default_nettype none

module json_string_escaper (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic [1:0] req_tuser,   // [0] has_byte, [1] first_of_string
   input  wire logic       req_tlast,   // last_of_string
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [6:0] out_char, [7] zero
   output logic            rsp_tuser,   // [0] string_end
   output logic            rsp_tlast    // last_of_run
);

   jse_pkg::job_type job;
   logic             accept;
   logic [6:0]       out_char;

   assign accept = req_tvalid && req_tready;

   jse_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_tdata),
      .has_byte        (req_tuser[0]),
      .first_of_string (req_tuser[1]),
      .last_of_string  (req_tlast),
      .job             (job)
   );

   jse_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .job_in    (job),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_char  (out_char),
      .rsp_last  (rsp_tlast),
      .rsp_end   (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

@@ rtl/jse_decode.sv @@
// UTF-8 decode and escape classification of one input transfer into tokens.
// Holds the partial-sequence state; uses jse_pkg.
`default_nettype none

module jse_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              has_byte,
   input  wire logic              first_of_string,
   input  wire logic              last_of_string,
   output jse_pkg::job_type       job
);

   localparam logic [20:0] REPL_CP = 21'h00fffd;

   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [2:0] seq_len_ff, seq_len_in;
   logic       nul_ff, nul_in;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] n;
      if (b < 8'h80)      n = 3'd1;
      else if (b < 8'he0) n = 3'd2;
      else if (b < 8'hf0) n = 3'd3;
      else if (b < 8'hf8) n = 3'd4;
      else                n = 3'd1;
      return n;
   endfunction

   function automatic logic [20:0] dec2(input logic [7:0] b0, input logic [7:0] b1);
      logic [10:0] c;
      c = {b0[4:0], b1[5:0]};
      return (c < 11'h080) ? REPL_CP : {10'b0, c};
   endfunction

   function automatic logic [20:0] dec3(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2);
      logic [15:0] c;
      c = {b0[3:0], b1[5:0], b2[5:0]};
      if ((c >= 16'hd800 && c <= 16'hdfff) || c < 16'h0800) return REPL_CP;
      return {5'b0, c};
   endfunction

   function automatic logic [20:0] dec4(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
      logic [20:0] c;
      c = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      return (c < 21'h010000) ? REPL_CP : c;
   endfunction

   function automatic jse_pkg::tok_type cp_tok(input logic [20:0] cp);
      logic [20:0]      d;
      jse_pkg::tok_type t;
      d = cp - 21'h010000;
      if (cp >= 21'h000020 && cp < 21'h000080) begin
         t = '{kind: jse_pkg::KIND_CHAR, hi: 16'h0, lo: cp[15:0]};
      end else if (cp < 21'h010000) begin
         t = '{kind: jse_pkg::KIND_U16, hi: 16'h0, lo: cp[15:0]};
      end else begin
         t = '{kind: jse_pkg::KIND_PAIR, hi: 16'hd800 + {5'b0, d[20:10]},
               lo: {6'b110111, d[9:0]}};
      end
      return t;
   endfunction

   function automatic jse_pkg::tok_type esc_tok(input logic [6:0] c);
      jse_pkg::tok_type t;
      t = '{kind: jse_pkg::KIND_ESC, hi: 16'h0, lo: {9'b0, c}};
      return t;
   endfunction

   // single-byte lead: escapes, ascii, or 0xf8 and up
   function automatic jse_pkg::tok_type single_tok(input logic [7:0] b);
      jse_pkg::tok_type t;
      case (b)
         8'h22:   t = esc_tok(7'h22);
         8'h5c:   t = esc_tok(7'h5c);
         8'h08:   t = esc_tok(7'h62);
         8'h0c:   t = esc_tok(7'h66);
         8'h0a:   t = esc_tok(7'h6e);
         8'h0d:   t = esc_tok(7'h72);
         8'h09:   t = esc_tok(7'h74);
         default: t = cp_tok((b < 8'h80) ? {13'b0, b} : REPL_CP);
      endcase
      return t;
   endfunction

   jse_pkg::tok_type quote_tok;
   assign quote_tok = '{kind: jse_pkg::KIND_CHAR, hi: 16'h0, lo: {9'b0, jse_pkg::CHAR_QUOTE}};

   always_comb begin
      logic       redo2;
      logic [2:0] l1;
      job         = '0;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      seq_len_in  = seq_len_ff;
      nul_in      = nul_ff;
      redo2       = 1'b0;
      l1          = lead_len(held_ff[1]);

      if (first_of_string) begin
         held_cnt_in = 2'd0;
         seq_len_in  = 3'd0;
         nul_in      = 1'b0;
         job.mask[jse_pkg::SLOT_OPEN] = 1'b1;
         job.toks[jse_pkg::SLOT_OPEN] = quote_tok;
      end

      if (has_byte && !nul_in) begin
         if (held_cnt_in != 2'd0 && {1'b0, held_cnt_in} < seq_len_in) begin
            if (held_cnt_in != 2'd3) begin
               held_in[held_cnt_in] = data_byte;
               held_cnt_in = held_cnt_in + 2'd1;
               if ({1'b0, held_cnt_in} == seq_len_in) begin
                  job.mask[jse_pkg::SLOT_BYTE] = 1'b1;
                  job.toks[jse_pkg::SLOT_BYTE] = (seq_len_in == 3'd2) ?
                     cp_tok(dec2(held_in[0], held_in[1])) :
                     cp_tok(dec3(held_in[0], held_in[1], held_in[2]));
                  held_cnt_in = 2'd0;
                  seq_len_in  = 3'd0;
               end
            end else begin
               // fourth byte of a four-byte form
               job.mask[jse_pkg::SLOT_BYTE] = 1'b1;
               job.toks[jse_pkg::SLOT_BYTE] =
                  cp_tok(dec4(held_in[0], held_in[1], held_in[2], data_byte));
               held_cnt_in = 2'd0;
               seq_len_in  = 3'd0;
            end
         end else if (data_byte == 8'h00) begin
            nul_in = 1'b1;
         end else if (lead_len(data_byte) == 3'd1) begin
            job.mask[jse_pkg::SLOT_BYTE] = 1'b1;
            job.toks[jse_pkg::SLOT_BYTE] = single_tok(data_byte);
         end else begin
            held_in[0]  = data_byte;
            held_cnt_in = 2'd1;
            seq_len_in  = lead_len(data_byte);
         end
      end

      if (last_of_string) begin
         // cut-off sequence: lead gives a replacement, later bytes re-decoded
         l1 = lead_len(held_in[1]);
         if (held_cnt_in != 2'd0) begin
            job.mask[jse_pkg::SLOT_REPL] = 1'b1;
            job.toks[jse_pkg::SLOT_REPL] = cp_tok(REPL_CP);
         end
         if (held_cnt_in >= 2'd2 && !nul_in && held_in[1] != 8'h00) begin
            job.mask[jse_pkg::SLOT_POS1] = 1'b1;
            if (l1 == 3'd1) begin
               job.toks[jse_pkg::SLOT_POS1] = single_tok(held_in[1]);
               redo2 = 1'b1;
            end else if (l1 == 3'd2 && held_cnt_in == 2'd3) begin
               job.toks[jse_pkg::SLOT_POS1] = cp_tok(dec2(held_in[1], held_in[2]));
            end else begin
               job.toks[jse_pkg::SLOT_POS1] = cp_tok(REPL_CP);
               redo2 = 1'b1;
            end
         end
         if (redo2 && held_cnt_in == 2'd3 && held_in[2] != 8'h00) begin
            job.mask[jse_pkg::SLOT_POS2] = 1'b1;
            job.toks[jse_pkg::SLOT_POS2] = (lead_len(held_in[2]) == 3'd1) ?
               single_tok(held_in[2]) : cp_tok(REPL_CP);
         end
         job.mask[jse_pkg::SLOT_CLOSE] = 1'b1;
         job.toks[jse_pkg::SLOT_CLOSE] = quote_tok;
         held_cnt_in = 2'd0;
         seq_len_in  = 3'd0;
         nul_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
         nul_ff      <= 1'b0;
      end else if (accept) begin
         held_cnt_ff <= held_cnt_in;
         seq_len_ff  <= seq_len_in;
         nul_ff      <= nul_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/jse_emit.sv @@
// Token register and character sequencer with the result output register.
// Walks the tokens of one transfer one character per cycle while the output is not stalled; uses jse_pkg.
`default_nettype none

module jse_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire jse_pkg::job_type  job_in,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [6:0]             rsp_char,
   output logic                   rsp_last,
   output logic                   rsp_end
);

   jse_pkg::job_type                  job_ff;
   logic                              job_valid_ff, job_valid_in;
   logic [jse_pkg::SLOT_W-1:0]        idx_ff, idx_in;
   logic [3:0]                        chr_ff, chr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [6:0]                        char_ff;
   logic                              last_ff, end_ff;

   jse_pkg::tok_type                  cur;
   logic [3:0]                        tok_len;
   logic                              last_chr, last_tok, out_load, job_done, job_load;
   logic [jse_pkg::SLOT_W:0]          nxt, first;
   logic [6:0]                        char_in;

   function automatic logic [6:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? 7'h30 + {3'b0, n} : 7'h57 + {3'b0, n};
   endfunction

   function automatic logic [6:0] u16_char(input logic [15:0] v, input logic [2:0] pos);
      logic [6:0] c;
      case (pos)
         3'd0:    c = jse_pkg::CHAR_BSLASH;
         3'd1:    c = jse_pkg::CHAR_U;
         3'd2:    c = hex_char(v[15:12]);
         3'd3:    c = hex_char(v[11:8]);
         3'd4:    c = hex_char(v[7:4]);
         3'd5:    c = hex_char(v[3:0]);
         default: c = jse_pkg::CHAR_BSLASH;
      endcase
      return c;
   endfunction

   // first set mask bit at or above from, with a found flag on top
   function automatic logic [jse_pkg::SLOT_W:0] find_slot(
      input logic [jse_pkg::NUM_SLOTS-1:0] mask, input logic [jse_pkg::SLOT_W-1:0] from);
      logic                       found;
      logic [jse_pkg::SLOT_W-1:0] idx;
      found = 1'b0;
      idx   = '0;
      for (int i = 0; i < jse_pkg::NUM_SLOTS; i++) begin
         if (!found && mask[i] && i >= int'(from)) begin
            found = 1'b1;
            idx   = jse_pkg::SLOT_W'(i);
         end
      end
      return {found, idx};
   endfunction

   assign cur      = job_ff.toks[idx_ff];
   assign nxt      = find_slot(job_ff.mask, idx_ff + 3'd1);
   assign first    = find_slot(job_in.mask, '0);
   assign last_tok = !nxt[jse_pkg::SLOT_W];

   always_comb begin
      case (cur.kind)
         jse_pkg::KIND_CHAR: begin
            tok_len = 4'd1;
            char_in = cur.lo[6:0];
         end
         jse_pkg::KIND_ESC: begin
            tok_len = 4'd2;
            char_in = (chr_ff == 4'd0) ? jse_pkg::CHAR_BSLASH : cur.lo[6:0];
         end
         jse_pkg::KIND_U16: begin
            tok_len = 4'd6;
            char_in = u16_char(cur.lo, chr_ff[2:0]);
         end
         default: begin
            tok_len = 4'd12;
            char_in = (chr_ff < 4'd6) ? u16_char(cur.hi, chr_ff[2:0]) :
                                        u16_char(cur.lo, 3'(chr_ff - 4'd6));
         end
      endcase
   end

   assign last_chr     = (chr_ff == tok_len - 4'd1);
   assign out_load     = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign job_done     = out_load && last_chr && last_tok;
   assign req_ready    = !job_valid_ff || job_done;
   assign job_load     = accept && (job_in.mask != '0);
   assign job_valid_in = job_load || (job_valid_ff && !job_done);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      idx_in = idx_ff;
      chr_in = chr_ff;
      if (job_load) begin
         idx_in = first[jse_pkg::SLOT_W-1:0];
         chr_in = 4'd0;
      end else if (out_load) begin
         if (last_chr) begin
            idx_in = nxt[jse_pkg::SLOT_W-1:0];
            chr_in = 4'd0;
         end else begin
            chr_in = chr_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         chr_ff       <= 4'd0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         chr_ff       <= chr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= job_in;
      end
      if (out_load) begin
         char_ff <= char_in;
         last_ff <= last_chr && last_tok;
         // the closing quote only ever sits in its own slot
         end_ff  <= last_chr && last_tok && (idx_ff == jse_pkg::SLOT_CLOSE);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = char_ff;
   assign rsp_last  = last_ff;
   assign rsp_end   = end_ff;

endmodule

`default_nettype wire
